### rtl/mf3_pkg.sv
// Package for the 3x3 median pixel filter: sizes, register indexes and the
// job record handed from the front end to the median back end.
// No dependencies.
`default_nettype none
package mf3_pkg;
   localparam int MAX_WIDTH   = 2048;
   localparam int MAX_HEIGHT  = 2048;
   localparam int COL_W       = 11;
   localparam int ROW_W       = 11;
   localparam int SIZE_W      = 12;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 12;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = 2;
   localparam int QCNT_W      = 3;

   localparam logic [CSR_IDX_W-1:0] CSR_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ALPHA  = 2'd2;

   localparam logic [SIZE_W-1:0] WIDTH_RESET  = 12'd640;
   localparam logic [SIZE_W-1:0] HEIGHT_RESET = 12'd480;

   typedef logic [31:0] pixel_type;            // {alpha, blue, green, red}
   typedef pixel_type [2:0][2:0] window_type;  // [column][row], oldest first
   typedef logic [8:0][7:0] nine_type;

   typedef struct packed {
      window_type       win;
      logic [COL_W-1:0] col;
      logic [ROW_W-1:0] row;
      logic             c_gt0;
      logic             c_ge2;
      logic             c_last;
      logic             r_gt0;
      logic             r_ge2;
      logic             r_last;
   } job_type;
endpackage
`default_nettype wire

### rtl/mf3_channels_if.sv
// Stream channels of the median filter: pixel requests and filtered responses.
// Depends on nothing.
`default_nettype none
interface mf3_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] red_in;
   logic [7:0] green_in;
   logic [7:0] blue_in;
   logic [7:0] alpha_in;
   modport source(output valid, red_in, green_in, blue_in, alpha_in, input ready);
   modport sink(input valid, red_in, green_in, blue_in, alpha_in, output ready);
endinterface

interface mf3_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  red_out;
   logic [7:0]  green_out;
   logic [7:0]  blue_out;
   logic [7:0]  alpha_out;
   logic [10:0] out_column;
   logic [10:0] out_row;
   logic        last_of_run;
   logic        frame_done;
   modport source(output valid, red_out, green_out, blue_out, alpha_out, out_column,
                  out_row, last_of_run, frame_done, input ready);
   modport sink(input valid, red_out, green_out, blue_out, alpha_out, out_column,
                out_row, last_of_run, frame_done, output ready);
endinterface
`default_nettype wire

### rtl/mf3_front.sv
// Front end: accepts pixels, tracks position, keeps the two line stores and
// the 3x3 window, and issues one job per pixel that completes outputs.
// Depends on mf3_pkg and mf3_req_if.
`default_nettype none
module mf3_front (
   input  wire logic                       clock,
   input  wire logic                       reset,
   mf3_req_if.sink                         req_chan,
   input  wire logic [mf3_pkg::SIZE_W-1:0] width_eff,
   input  wire logic [mf3_pkg::SIZE_W-1:0] height_eff,
   input  wire logic [mf3_pkg::QCNT_W-1:0] queue_count,
   output logic                            job_valid,
   output mf3_pkg::job_type                job
);
   import mf3_pkg::*;

   pixel_type upper_mem [MAX_WIDTH];
   pixel_type middle_mem [MAX_WIDTH];

   logic [COL_W-1:0] col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic [COL_W-1:0] c0;
   logic [ROW_W-1:0] r0;
   logic             accept;
   logic [QCNT_W-1:0] in_flight;

   logic             s1_valid_ff;
   logic [COL_W-1:0] s1_col_ff;
   logic [ROW_W-1:0] s1_row_ff;
   pixel_type        s1_px_ff;
   logic [5:0]       s1_flags_ff, flags_in;
   pixel_type        up_rd_ff, mid_rd_ff, byp_up_ff, byp_mid_ff;
   logic             hit_ff;
   pixel_type        up_val, mid_val;
   window_type       win_ff, win_in;

   assign c0 = ({1'b0, col_ff} >= width_eff) ? '0 : col_ff;
   assign r0 = ({1'b0, row_ff} >= height_eff) ? '0 : row_ff;

   // jobs in stage 1 are counted against the queue so stage 1 never stalls
   assign in_flight      = queue_count + QCNT_W'(s1_valid_ff);
   assign req_chan.ready = in_flight < QCNT_W'(QUEUE_DEPTH);
   assign accept         = req_chan.valid && req_chan.ready;

   always_comb begin
      col_in = c0 + 1'b1;
      row_in = r0;
      if ({1'b0, c0} + 1'b1 >= width_eff) begin
         col_in = '0;
         row_in = ({1'b0, r0} + 1'b1 >= height_eff) ? '0 : r0 + 1'b1;
      end
   end

   assign flags_in = {c0 != '0, c0 >= COL_W'(2), {1'b0, c0} == width_eff - 1'b1,
                      r0 != '0, r0 >= ROW_W'(2), {1'b0, r0} == height_eff - 1'b1};

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff      <= '0;
         row_ff      <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
         if (accept) begin
            col_ff <= col_in;
            row_ff <= row_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      up_rd_ff  <= upper_mem[c0];
      mid_rd_ff <= middle_mem[c0];
      // same-address write in this cycle (one-pixel-wide rows)
      hit_ff     <= s1_valid_ff && (s1_col_ff == c0);
      byp_up_ff  <= mid_val;
      byp_mid_ff <= s1_px_ff;
      if (accept) begin
         s1_col_ff   <= c0;
         s1_row_ff   <= r0;
         s1_px_ff    <= {req_chan.alpha_in, req_chan.blue_in, req_chan.green_in,
                         req_chan.red_in};
         s1_flags_ff <= flags_in;
      end
      if (s1_valid_ff) begin
         upper_mem[s1_col_ff]  <= mid_val;
         middle_mem[s1_col_ff] <= s1_px_ff;
      end
   end

   assign up_val  = hit_ff ? byp_up_ff : up_rd_ff;
   assign mid_val = hit_ff ? byp_mid_ff : mid_rd_ff;

   always_comb begin
      win_in       = win_ff;
      win_in[0]    = win_ff[1];
      win_in[1]    = win_ff[2];
      win_in[2][0] = up_val;
      win_in[2][1] = mid_val;
      win_in[2][2] = s1_px_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff <= '0;
      end else if (s1_valid_ff) begin
         win_ff <= win_in;
      end
   end

   assign job.win    = win_in;
   assign job.col    = s1_col_ff;
   assign job.row    = s1_row_ff;
   assign job.c_gt0  = s1_flags_ff[5];
   assign job.c_ge2  = s1_flags_ff[4];
   assign job.c_last = s1_flags_ff[3];
   assign job.r_gt0  = s1_flags_ff[2];
   assign job.r_ge2  = s1_flags_ff[1];
   assign job.r_last = s1_flags_ff[0];
   assign job_valid  = s1_valid_ff && (s1_flags_ff[5] || s1_flags_ff[3])
                       && (s1_flags_ff[2] || s1_flags_ff[0]);
endmodule
`default_nettype wire

### rtl/mf3_job_queue.sv
// Short queue of jobs between the front end and the median back end.
// Depends on mf3_pkg.
`default_nettype none
module mf3_job_queue (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       push,
   input  wire mf3_pkg::job_type           push_job,
   input  wire logic                       pop,
   output mf3_pkg::job_type                head,
   output logic                            not_empty,
   output logic [mf3_pkg::QCNT_W-1:0]      count
);
   import mf3_pkg::*;

   job_type           slots [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QCNT_W-1:0] count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (pop) rd_ptr_ff <= rd_ptr_ff + 1'b1;
         count_ff <= count_ff + QCNT_W'(push) - QCNT_W'(pop);
      end
   end

   always_ff @(posedge clock) begin
      if (push) slots[wr_ptr_ff] <= push_job;
   end

   assign head      = slots[rd_ptr_ff];
   assign not_empty = count_ff != '0;
   assign count     = count_ff;
endmodule
`default_nettype wire

### rtl/mf3_back.sv
// Back end: expands each job into its outputs and finds the per-channel
// median through a rank-select pipeline. Depends on mf3_pkg and mf3_rsp_if.
`default_nettype none
module mf3_back (
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire mf3_pkg::job_type head,
   input  wire logic      not_empty,
   input  wire logic      alpha_en,
   output logic           pop,
   mf3_rsp_if.source      rsp_chan
);
   import mf3_pkg::*;

   function automatic logic [3:0] low_pads(input logic [3:0] n);
      case (n)
         4'd1, 4'd2: low_pads = 4'd4;
         4'd3, 4'd4: low_pads = 4'd3;
         4'd6:       low_pads = 4'd2;
         default:    low_pads = 4'd0;
      endcase
   endfunction

   logic en, take, last_col, last_row, is_cur_col, is_cur_row;
   logic col_sel_ff, row_sel_ff;
   logic [2:0] cmask, rmask;
   logic [1:0] pc, pr;
   logic [3:0] n, plow, lowcnt;
   nine_type [2:0] pad;
   logic [1:0] awx, awy;

   // stage 0
   logic           v0_ff, even0_ff, last0_ff, frame0_ff;
   nine_type [2:0] vals0_ff;
   logic [7:0]     alpha0_ff;
   logic [COL_W-1:0] ox0_ff;
   logic [ROW_W-1:0] oy0_ff;
   // stage 1
   logic           v1_ff, even1_ff, last1_ff, frame1_ff;
   nine_type [2:0] vals1_ff;
   logic [2:0][8:0][8:0] lt1_ff;
   logic [7:0]     alpha1_ff;
   logic [COL_W-1:0] ox1_ff;
   logic [ROW_W-1:0] oy1_ff;
   // stage 2
   logic           v2_ff, even2_ff, last2_ff, frame2_ff;
   logic [2:0][7:0] s4_ff, s5_ff, s4_in, s5_in;
   logic [7:0]     alpha2_ff;
   logic [COL_W-1:0] ox2_ff;
   logic [ROW_W-1:0] oy2_ff;
   // output
   logic           out_valid_ff, out_last_ff, out_frame_ff;
   logic [2:0][7:0] out_ff;
   logic [7:0]     out_alpha_ff;
   logic [COL_W-1:0] out_col_ff;
   logic [ROW_W-1:0] out_row_ff;

   assign en   = !out_valid_ff || rsp_chan.ready;
   assign take = en && not_empty;

   assign last_col   = !(head.c_gt0 && head.c_last) || col_sel_ff;
   assign last_row   = !(head.r_gt0 && head.r_last) || row_sel_ff;
   assign is_cur_col = !head.c_gt0 || col_sel_ff;
   assign is_cur_row = !head.r_gt0 || row_sel_ff;
   assign pop        = take && last_col && last_row;

   always_ff @(posedge clock) begin
      if (reset) begin
         col_sel_ff <= 1'b0;
         row_sel_ff <= 1'b0;
      end else if (take) begin
         if (last_col) begin
            col_sel_ff <= 1'b0;
            row_sel_ff <= last_row ? 1'b0 : 1'b1;
         end else begin
            col_sel_ff <= 1'b1;
         end
      end
   end

   // neighbors inside the image, by window column and row
   assign cmask = is_cur_col ? {1'b1, head.c_gt0, 1'b0} : {1'b1, 1'b1, head.c_ge2};
   assign rmask = is_cur_row ? {1'b1, head.r_gt0, 1'b0} : {1'b1, 1'b1, head.r_ge2};
   assign pc    = 2'($countones(cmask));
   assign pr    = 2'($countones(rmask));
   assign n     = {2'b00, pc} * {2'b00, pr};
   assign plow  = low_pads(n);
   assign awx   = is_cur_col ? 2'd2 : 2'd1;
   assign awy   = is_cur_row ? 2'd2 : 2'd1;

   // missing neighbors become 0 or 255 so that the median lands on slot 4, or on slots 4 and 5 averaged for even counts
   always_comb begin
      lowcnt = '0;
      pad    = '0;
      for (int k = 0; k < 9; k++) begin
         if (cmask[k / 3] && rmask[k % 3]) begin
            for (int ch = 0; ch < 3; ch++) pad[ch][k] = head.win[k / 3][k % 3][8 * ch +: 8];
         end else if (lowcnt < plow) begin
            lowcnt = lowcnt + 1'b1;
         end else begin
            for (int ch = 0; ch < 3; ch++) pad[ch][k] = 8'hFF;
         end
      end
   end

   always_comb begin
      s4_in = '0;
      s5_in = '0;
      for (int ch = 0; ch < 3; ch++) begin
         for (int i = 0; i < 9; i++) begin
            if (4'($countones(lt1_ff[ch][i])) == 4'd4) s4_in[ch] = s4_in[ch] | vals1_ff[ch][i];
            if (4'($countones(lt1_ff[ch][i])) == 4'd5) s5_in[ch] = s5_in[ch] | vals1_ff[ch][i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff        <= 1'b0;
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (en) begin
         v0_ff        <= take;
         v1_ff        <= v0_ff;
         v2_ff        <= v1_ff;
         out_valid_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         vals0_ff  <= pad;
         even0_ff  <= (pc == 2'd2) || (pr == 2'd2);
         alpha0_ff <= alpha_en ? head.win[awx][awy][31:24] : 8'h00;
         ox0_ff    <= is_cur_col ? head.col : head.col - 1'b1;
         oy0_ff    <= is_cur_row ? head.row : head.row - 1'b1;
         last0_ff  <= last_col && last_row;
         frame0_ff <= is_cur_col && head.c_last && is_cur_row && head.r_last;

         // ranks with ties broken by slot
         for (int ch = 0; ch < 3; ch++)
            for (int i = 0; i < 9; i++)
               for (int j = 0; j < 9; j++)
                  lt1_ff[ch][i][j] <= (vals0_ff[ch][j] < vals0_ff[ch][i])
                                      || ((vals0_ff[ch][j] == vals0_ff[ch][i]) && (j < i));
         vals1_ff  <= vals0_ff;
         even1_ff  <= even0_ff;
         alpha1_ff <= alpha0_ff;
         ox1_ff    <= ox0_ff;
         oy1_ff    <= oy0_ff;
         last1_ff  <= last0_ff;
         frame1_ff <= frame0_ff;

         s4_ff     <= s4_in;
         s5_ff     <= s5_in;
         even2_ff  <= even1_ff;
         alpha2_ff <= alpha1_ff;
         ox2_ff    <= ox1_ff;
         oy2_ff    <= oy1_ff;
         last2_ff  <= last1_ff;
         frame2_ff <= frame1_ff;

         for (int ch = 0; ch < 3; ch++)
            out_ff[ch] <= even2_ff ? 8'(({1'b0, s4_ff[ch]} + {1'b0, s5_ff[ch]}) >> 1)
                                   : s4_ff[ch];
         out_alpha_ff <= alpha2_ff;
         out_col_ff   <= ox2_ff;
         out_row_ff   <= oy2_ff;
         out_last_ff  <= last2_ff;
         out_frame_ff <= frame2_ff;
      end
   end

   assign rsp_chan.valid       = out_valid_ff;
   assign rsp_chan.red_out     = out_ff[0];
   assign rsp_chan.green_out   = out_ff[1];
   assign rsp_chan.blue_out    = out_ff[2];
   assign rsp_chan.alpha_out   = out_alpha_ff;
   assign rsp_chan.out_column  = out_col_ff;
   assign rsp_chan.out_row     = out_row_ff;
   assign rsp_chan.last_of_run = out_last_ff;
   assign rsp_chan.frame_done  = out_frame_ff;
endmodule
`default_nettype wire

### rtl/median3x3_pixel_filter.sv
// Top level of the 3x3 median pixel filter: configuration registers and the
// front end, job queue and back end. Depends on mf3_pkg, the channel interfaces,
// mf3_front, mf3_job_queue and mf3_back.
// Pixels arrive in raster order, one per cycle when the response side keeps up.
// The back end produces one result per cycle while the response side is ready, so
// at a row end (up to four results) and along the last row (two per pixel) the
// four-entry job queue fills and the request side waits. Line stores are
// single-write, single-read memories with no clearing pass. Change the size only
// while no transaction is in flight.
`default_nettype none
module median3x3_pixel_filter (
   input  wire logic                           clock,
   input  wire logic                           reset,
   mf3_req_if.sink                             req_chan,
   mf3_rsp_if.source                           rsp_chan,
   input  wire logic                           csr_we,
   input  wire logic [mf3_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [mf3_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import mf3_pkg::*;

   logic [SIZE_W-1:0] width_ff, height_ff, width_eff, height_eff;
   logic              alpha_ff;
   logic              job_valid, pop, not_empty;
   job_type           job, head;
   logic [QCNT_W-1:0] queue_count;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
         alpha_ff  <= 1'b0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_WIDTH:  width_ff  <= csr_wdata;
            CSR_HEIGHT: height_ff <= csr_wdata;
            CSR_ALPHA:  alpha_ff  <= csr_wdata[0];
            default:    ;
         endcase
      end
   end

   always_comb begin
      width_eff = width_ff;
      if (width_ff == '0) width_eff = SIZE_W'(1);
      else if (width_ff > SIZE_W'(MAX_WIDTH)) width_eff = SIZE_W'(MAX_WIDTH);
      height_eff = height_ff;
      if (height_ff == '0) height_eff = SIZE_W'(1);
      else if (height_ff > SIZE_W'(MAX_HEIGHT)) height_eff = SIZE_W'(MAX_HEIGHT);
   end

   mf3_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .width_eff   (width_eff),
      .height_eff  (height_eff),
      .queue_count (queue_count),
      .job_valid   (job_valid),
      .job         (job)
   );

   mf3_job_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (job_valid),
      .push_job  (job),
      .pop       (pop),
      .head      (head),
      .not_empty (not_empty),
      .count     (queue_count)
   );

   mf3_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .not_empty (not_empty),
      .alpha_en  (alpha_ff),
      .pop       (pop),
      .rsp_chan  (rsp_chan)
   );
endmodule
`default_nettype wire

### rtl/mf3_checker.sv
// Port-level checks for the median filter, bound to the top level.
// Depends on median3x3_pixel_filter and its channel interfaces.
`default_nettype none
module mf3_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic        last_of_run,
   input wire logic        frame_done,
   input wire logic [10:0] out_column,
   input wire logic [10:0] out_row
);
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid right after reset");

   a_frame_ends_run: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && frame_done |-> last_of_run)
      else $error("frame end not the last result of its transaction");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(out_column) && $stable(out_row))
      else $error("stalled response changed");
endmodule

bind median3x3_pixel_filter mf3_checker u_mf3_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_chan.valid),
   .rsp_ready   (rsp_chan.ready),
   .last_of_run (rsp_chan.last_of_run),
   .frame_done  (rsp_chan.frame_done),
   .out_column  (rsp_chan.out_column),
   .out_row     (rsp_chan.out_row)
);
`default_nettype wire

### tb/sv/tb_median3x3_pixel_filter.sv
// Self-checking testbench for median3x3_pixel_filter: streams raster-order pixels,
// predicts each 3x3 median result locally and compares every response transaction.
// Depends on mf3_pkg, the mf3 channel interfaces and the filter top level.
`timescale 1ns / 1ps
module tb_median3x3_pixel_filter;
   import mf3_pkg::*;

   localparam int RUN_LIMIT = 1_500_000;
   localparam int SETTLE    = 12;

   typedef struct {
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
      logic [7:0]  alpha;
      logic [10:0] column;
      logic [10:0] row;
      logic        last_of_run;
      logic        frame_done;
   } filtered_px_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                  csr_we    = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = CSR_WIDTH;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   mf3_req_if req_chan();
   mf3_rsp_if rsp_chan();

   median3x3_pixel_filter dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #2 clock = ~clock;

   // local copy of the filter state
   logic [SIZE_W-1:0] width_reg  = WIDTH_RESET;
   logic [SIZE_W-1:0] height_reg = HEIGHT_RESET;
   logic              alpha_reg  = 1'b0;
   logic [31:0] upper_row [MAX_WIDTH];
   logic [31:0] middle_row [MAX_WIDTH];
   logic [31:0] win [3][3];   // [column oldest..newest][row oldest..newest]
   int col_pos = 0;
   int row_pos = 0;

   filtered_px_type pending_px[$];
   int errors = 0;
   int pixels_sent = 0;
   int results_seen = 0;
   int frames_seen = 0;
   int cycle_count = 0;
   int gap_left = 0;
   int burst_left = 0;
   int stall_mode = 0;

   initial begin
      for (int i = 0; i < MAX_WIDTH; i++) begin
         upper_row[i] = '0;
         middle_row[i] = '0;
      end
      for (int i = 0; i < 3; i++)
         for (int j = 0; j < 3; j++)
            win[i][j] = '0;
      req_chan.valid = 1'b0;
      req_chan.red_in = '0;
      req_chan.green_in = '0;
      req_chan.blue_in = '0;
      req_chan.alpha_in = '0;
      rsp_chan.ready = 1'b0;
   end

   function automatic int clamp_size(logic [SIZE_W-1:0] v, int max_v);
      if (v == 0) return 1;
      if (int'(v) > max_v) return max_v;
      return int'(v);
   endfunction

   function automatic logic [7:0] median_of(logic [7:0] v[9], int n);
      logic [7:0] t;
      int j;
      for (int i = 1; i < n; i++) begin
         t = v[i];
         j = i - 1;
         while (j >= 0 && v[j] > t) begin
            v[j+1] = v[j];
            j--;
         end
         v[j+1] = t;
      end
      if (n % 2 == 0) return 8'((9'(v[n/2-1]) + 9'(v[n/2])) >> 1);
      return v[n/2];
   endfunction

   function automatic filtered_px_type filter_at(int ox, int oy, int c, int r, int w, int h);
      filtered_px_type fp;
      logic [7:0] vals[9];
      logic [7:0] med[3];
      int n, nx, ny, wx, wy;
      for (int ch = 0; ch < 3; ch++) begin
         n = 0;
         for (int dy = -1; dy <= 1; dy++)
            for (int dx = -1; dx <= 1; dx++) begin
               nx = ox + dx;
               ny = oy + dy;
               wx = nx - c + 2;
               wy = ny - r + 2;
               if (nx >= 0 && nx < w && ny >= 0 && ny < h &&
                   wx >= 0 && wx <= 2 && wy >= 0 && wy <= 2) begin
                  vals[n] = win[wx][wy][8*ch +: 8];
                  n++;
               end
            end
         med[ch] = (n > 0) ? median_of(vals, n) : 8'd0;
      end
      fp.red = med[0];
      fp.green = med[1];
      fp.blue = med[2];
      wx = ox - c + 2;
      wy = oy - r + 2;
      fp.alpha = (alpha_reg && wx >= 0 && wx <= 2 && wy >= 0 && wy <= 2) ?
                 win[wx][wy][31:24] : 8'd0;
      fp.column = 11'(ox);
      fp.row = 11'(oy);
      fp.last_of_run = 1'b0;
      fp.frame_done = (ox == w - 1) && (oy == h - 1);
      return fp;
   endfunction

   // advance the local filter by one accepted pixel and queue what it completes
   function automatic void predict_pixel(logic [31:0] px);
      int w, h, c, r, nc, nr, n;
      int cols[2];
      int rows[2];
      filtered_px_type fp;
      w = clamp_size(width_reg, MAX_WIDTH);
      h = clamp_size(height_reg, MAX_HEIGHT);
      c = (col_pos >= w) ? 0 : col_pos;
      r = (row_pos >= h) ? 0 : row_pos;
      for (int i = 0; i < 2; i++)
         for (int j = 0; j < 3; j++)
            win[i][j] = win[i+1][j];
      win[2][0] = upper_row[c];
      win[2][1] = middle_row[c];
      win[2][2] = px;
      upper_row[c] = middle_row[c];
      middle_row[c] = px;
      nc = 0;
      nr = 0;
      n = 0;
      if (c > 0) cols[nc++] = c - 1;
      if (c == w - 1) cols[nc++] = c;
      if (r > 0) rows[nr++] = r - 1;
      if (r == h - 1) rows[nr++] = r;
      for (int i = 0; i < nr; i++)
         for (int j = 0; j < nc; j++) begin
            fp = filter_at(cols[j], rows[i], c, r, w, h);
            n++;
            if (i == nr - 1 && j == nc - 1) fp.last_of_run = 1'b1;
            pending_px.push_back(fp);
         end
      c++;
      if (c >= w) begin
         c = 0;
         r++;
         if (r >= h) r = 0;
      end
      col_pos = c;
      row_pos = r;
   endfunction

   // called just after a falling edge; returns just after a falling edge
   task automatic send_pixel(input logic [7:0] red, input logic [7:0] green,
                             input logic [7:0] blue, input logic [7:0] alpha);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      end
      if (gap_left > 0) begin
         req_chan.valid = 1'b0;
         repeat (gap_left) @(negedge clock);
         gap_left = 0;
      end
      burst_left--;
      req_chan.valid = 1'b1;
      req_chan.red_in = red;
      req_chan.green_in = green;
      req_chan.blue_in = blue;
      req_chan.alpha_in = alpha;
      forever begin
         @(posedge clock);
         if (req_chan.ready) break;
      end
      predict_pixel({alpha, blue, green, red});
      pixels_sent++;
      @(negedge clock);
   endtask

   task automatic send_random_pixel();
      logic [7:0] base;
      base = 8'($urandom);
      // narrow-range pixels now and then so ties and near-ties show up
      if ($urandom_range(0, 3) == 0)
         send_pixel(base ^ 8'($urandom_range(0, 3)), base ^ 8'($urandom_range(0, 3)),
                    base, 8'($urandom));
      else
         send_pixel(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
   endtask

   task automatic wait_drained();
      req_chan.valid = 1'b0;
      while (pending_px.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input int value);
      csr_we = 1'b1;
      csr_index = idx;
      csr_wdata = CSR_DATA_W'(value);
      @(negedge clock);
      csr_we = 1'b0;
      case (idx)
         CSR_WIDTH:  width_reg = SIZE_W'(value);
         CSR_HEIGHT: height_reg = SIZE_W'(value);
         CSR_ALPHA:  alpha_reg = value[0];
         default: ;
      endcase
   endtask

   task automatic set_frame(input int w, input int h, input int alpha);
      wait_drained();
      write_reg(CSR_WIDTH, w);
      write_reg(CSR_HEIGHT, h);
      write_reg(CSR_ALPHA, alpha);
   endtask

   task automatic finish_frame();
      do send_random_pixel(); while (!(col_pos == 0 && row_pos == 0));
   endtask

   task automatic test_small_frames();
      set_frame(3, 3, 1);
      send_pixel(8'h00, 8'hFF, 8'h00, 8'hFF);
      send_pixel(8'hFF, 8'h00, 8'hFF, 8'h00);
      send_pixel(8'h80, 8'h7F, 8'h01, 8'hAA);
      send_pixel(8'h00, 8'h00, 8'hFE, 8'h55);
      send_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF);
      send_pixel(8'h01, 8'h80, 8'h7F, 8'h00);
      send_pixel(8'hFF, 8'h00, 8'h00, 8'h0F);
      send_pixel(8'h00, 8'hFF, 8'h00, 8'hF0);
      send_pixel(8'h00, 8'h00, 8'hFF, 8'h3C);
      // even neighbor counts: halves of odd sums round down
      set_frame(2, 2, 0);
      send_pixel(8'hFF, 8'h00, 8'h01, 8'hFF);
      send_pixel(8'hFE, 8'h01, 8'h02, 8'h12);
      send_pixel(8'h00, 8'hFF, 8'h03, 8'h34);
      send_pixel(8'h01, 8'hFE, 8'h04, 8'h56);
      set_frame(1, 1, 1);
      send_pixel(8'hA5, 8'h5A, 8'hC3, 8'h3C);
      // zero sizes behave as one
      set_frame(0, 0, 1);
      send_pixel(8'h12, 8'h34, 8'h56, 8'h78);
      set_frame(1, 4, 0);
      repeat (4) send_random_pixel();
      set_frame(5, 1, 1);
      repeat (5) send_random_pixel();
   endtask

   task automatic test_size_limits();
      // oversized widths and heights clamp to the maximum; partial frames only,
      // the next size change restarts the position
      set_frame(4095, 1, 1);
      repeat (24) send_random_pixel();
      set_frame(1, 4095, 0);
      repeat (24) send_random_pixel();
      set_frame(MAX_WIDTH, 2, 1);
      repeat (24) send_random_pixel();
   endtask

   task automatic test_shrink_midframe();
      set_frame(8, 8, 1);
      repeat (13) send_random_pixel();
      wait_drained();
      write_reg(CSR_WIDTH, 4);   // column now past the row end, restarts at 0
      finish_frame();
      set_frame(4, 8, 0);
      repeat (22) send_random_pixel();
      wait_drained();
      write_reg(CSR_HEIGHT, 3);  // row past the new height restarts at 0
      finish_frame();
   endtask

   task automatic test_random_frames();
      int frame_no;
      frame_no = 0;
      while (pixels_sent < 330) begin
         set_frame($urandom_range(1, 12), $urandom_range(1, 10), $urandom_range(0, 1));
         if (frame_no == 1) begin
            repeat (3) send_random_pixel();
            wait_drained();   // hold off until everything in flight has come back
         end
         finish_frame();
         frame_no++;
      end
   endtask

   always @(negedge clock) begin
      if ($urandom_range(0, 63) == 0) stall_mode <= $urandom_range(0, 2);
      case (stall_mode)
         0: rsp_chan.ready <= 1'b1;
         1: rsp_chan.ready <= ($urandom_range(0, 9) < 7);
         default: rsp_chan.ready <= ($urandom_range(0, 3) == 0);
      endcase
   end

   task automatic check_field(input string name, input int want, input int got);
      if (want != got) begin
         $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
         errors++;
      end
   endtask

   always @(posedge clock) begin
      filtered_px_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (pending_px.size() == 0) begin
            $display("%0t: unexpected result at column %0d row %0d", $time,
                     rsp_chan.out_column, rsp_chan.out_row);
            errors++;
         end else begin
            want = pending_px.pop_front();
            check_field("red_out", want.red, rsp_chan.red_out);
            check_field("green_out", want.green, rsp_chan.green_out);
            check_field("blue_out", want.blue, rsp_chan.blue_out);
            check_field("alpha_out", want.alpha, rsp_chan.alpha_out);
            check_field("out_column", want.column, rsp_chan.out_column);
            check_field("out_row", want.row, rsp_chan.out_row);
            check_field("last_of_run", want.last_of_run, rsp_chan.last_of_run);
            check_field("frame_done", want.frame_done, rsp_chan.frame_done);
            results_seen++;
            if (want.frame_done) frames_seen++;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > RUN_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   initial begin
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      @(negedge clock);
      test_small_frames();
      test_shrink_midframe();
      test_size_limits();
      test_random_frames();
      wait_drained();
      if (pending_px.size() != 0) begin
         $display("%0t: %0d expected results never arrived", $time, pending_px.size());
         errors++;
      end
      $display("Covered %0d pixels, %0d filtered results, %0d complete frames,",
               pixels_sent, results_seen, frames_seen);
      $display("sizes from 1x1 up to clamped maximum width and height, %0d errors", errors);
      if (errors == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end
endmodule
